### rtl/core/chrl_pkg.sv
// Shared types and codes for the consistent-hash ring lookup block.
// No dependencies; imported by every module of the block.
package chrl_pkg;

    localparam int HASH_BITS  = 32;
    localparam int OWNER_BITS = 8;
    localparam int COUNT_BITS = 7;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [HASH_BITS-1:0]  hash_value;
        logic [OWNER_BITS-1:0] node_id;
    } chrl_req_t;

    typedef struct packed {
        logic [OWNER_BITS-1:0] owner_node;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] point_count;
    } chrl_res_t;

endpackage

### rtl/core/chrl_engine.sv
// Ring storage and search/insert sequencer for the hash ring lookup block.
// Depends on chrl_pkg; holds the sorted point memory and one shared comparator.
module chrl_engine #(
    parameter int RING_POINTS  = 64,
    parameter int NODE_ID_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  chrl_pkg::chrl_req_t req,
    output logic               res_valid,
    input  logic               res_ready,
    output chrl_pkg::chrl_res_t res
);
    import chrl_pkg::*;

    localparam int AW = (RING_POINTS > 1) ? $clog2(RING_POINTS) : 1;
    localparam int CW = $clog2(RING_POINTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(RING_POINTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_PLACE  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [HASH_BITS-1:0]    ring_hash_mem [RING_POINTS];
    logic [NODE_ID_BITS-1:0] ring_node_mem [RING_POINTS];

    logic [2:0]              state_reg, state_next;
    logic                    op_reg, op_next;
    logic [HASH_BITS-1:0]    hash_reg, hash_next;
    logic [NODE_ID_BITS-1:0] node_reg, node_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           used_reg, used_next;
    logic [OWNER_BITS-1:0]   owner_reg, owner_next;
    logic [1:0]              status_reg, status_next;

    logic [HASH_BITS-1:0]    rd_hash_reg;
    logic [NODE_ID_BITS-1:0] rd_node_reg;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [HASH_BITS-1:0]    wr_hash;
    logic [NODE_ID_BITS-1:0] wr_node;

    logic                    hash_lt;
    logic [CW-1:0]           cmp_lo, cmp_hi, cmp_mid;
    logic [NODE_ID_BITS+7:0] node_in_ext;
    logic [NODE_ID_BITS+7:0] owner_ext;
    logic [CW+6:0]           count_ext;

    function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return a + ((b - a) >> 1);
    endfunction

    // the shared comparator: one binary-search step per cycle
    assign hash_lt = rd_hash_reg < hash_reg;
    assign cmp_lo  = hash_lt ? mid_reg + CW'(1) : lo_reg;
    assign cmp_hi  = hash_lt ? hi_reg : mid_reg;
    assign cmp_mid = mid_of(cmp_lo, cmp_hi);

    assign node_in_ext = {{NODE_ID_BITS{1'b0}}, req.node_id};
    assign owner_ext   = {8'b0, rd_node_reg};
    assign count_ext   = {7'b0, used_reg};

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        hash_next   = hash_reg;
        node_next   = node_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        used_next   = used_reg;
        owner_next  = owner_reg;
        status_next = status_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = lo_reg[AW-1:0];
        wr_hash     = hash_reg;
        wr_node     = node_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next     = req.action;
                    hash_next   = req.hash_value;
                    node_next   = node_in_ext[NODE_ID_BITS-1:0];
                    lo_next     = '0;
                    hi_next     = used_reg;
                    owner_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_of(lo_reg, hi_reg);
                    rd_addr    = mid_next[AW-1:0];
                    state_next = S_CMP;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP: begin
                lo_next = cmp_lo;
                hi_next = cmp_hi;
                if (cmp_lo < cmp_hi) begin
                    mid_next = cmp_mid;
                    rd_addr  = cmp_mid[AW-1:0];
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // flag an empty lookup; else fetch search point, wrap to lowest
                if (op_reg == ACT_LOOKUP && used_reg == '0) begin
                    status_next = ST_EMPTY;
                    state_next  = S_RESP;
                end else begin
                    rd_addr    = (lo_reg == used_reg) ? '0 : lo_reg[AW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (op_reg == ACT_LOOKUP) begin
                    owner_next = owner_ext[7:0];
                    state_next = S_RESP;
                end else if (lo_reg != used_reg && rd_hash_reg == hash_reg) begin
                    wr_en      = 1'b1;
                    state_next = S_RESP;
                end else if (used_reg == FULL_COUNT) begin
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end else if (used_reg > lo_reg) begin
                    hi_next    = used_reg;
                    rd_addr    = AW'(used_reg - CW'(1));
                    state_next = S_SHIFT;
                end else begin
                    wr_en      = 1'b1;
                    used_next  = used_reg + CW'(1);
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                // move entry k-1 up to k, walking down toward the insert position
                wr_en   = 1'b1;
                wr_addr = hi_reg[AW-1:0];
                wr_hash = rd_hash_reg;
                wr_node = rd_node_reg;
                hi_next = hi_reg - CW'(1);
                if (hi_next > lo_reg) begin
                    rd_addr = AW'(hi_reg - CW'(2));
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                wr_en      = 1'b1;
                used_next  = used_reg + CW'(1);
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        hash_reg   <= hash_next;
        node_reg   <= node_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        owner_reg  <= owner_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_hash_mem[wr_addr] <= wr_hash;
            ring_node_mem[wr_addr] <= wr_node;
        end
        rd_hash_reg <= ring_hash_mem[rd_addr];
        rd_node_reg <= ring_node_mem[rd_addr];
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_RESP);
    assign res.owner_node  = owner_reg;
    assign res.status      = status_reg;
    assign res.point_count = count_ext[COUNT_BITS-1:0];

endmodule

### rtl/core/consistent_hash_ring_lookup.sv
// Top level of the consistent-hash ring lookup block: stream ports and result register.
// Depends on chrl_pkg and chrl_engine.
//
//   Requests enter on the s_axis channel. s_axis_tuser selects the action
//   (insert a hash point or look up the owner of a hash); s_axis_tdata carries
//   the hash and, for inserts, the owning node id. Every request produces
//   exactly one result on the m_axis channel: the owner node, a status in
//   m_axis_tuser (ok, ring full, ring empty) and the point count afterwards.
//   Points are kept sorted in an on-chip memory with a registered read port;
//   one comparator walks a binary search over them, one step per cycle.
//   A search takes up to ceil(log2(points + 1)) steps. A new point below the
//   top is placed once each point above it has moved up one slot, one at a
//   time through the single memory write port, to open the gap. s_axis_tready
//   is high only while the sequencer is idle, and the sequencer returns to
//   idle as the result register loads. A result waiting there does not block
//   the next request; only the following result waits for it.
//   If the receiver stalls, m_axis_tvalid and m_axis_tdata hold.
//   Reset empties the ring (point count zero) and drops any held result.
module consistent_hash_ring_lookup #(
    parameter int RING_POINTS  = 64,
    parameter int NODE_ID_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] hash_value, [39:32] node_id
    input  logic [0:0]  s_axis_tuser,  // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] owner_node, [14:8] point_count, [15] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import chrl_pkg::*;

    chrl_req_t req;
    chrl_res_t res;
    logic      res_valid;
    logic      res_ready;

    logic      m_valid_reg, m_valid_next;
    chrl_res_t m_data_reg, m_data_next;

    // unpack the request
    assign req.action     = s_axis_tuser[0];
    assign req.hash_value = s_axis_tdata[31:0];
    assign req.node_id    = s_axis_tdata[39:32];

    chrl_engine #(
        .RING_POINTS  (RING_POINTS),
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: load when empty or when the current result is taken
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_data_reg.point_count, m_data_reg.owner_node};
    assign m_axis_tuser  = m_data_reg.status;

endmodule

### rtl/core/chrl_checker.sv
// Port-level assertions for the consistent-hash ring lookup block.
// Depends on chrl_pkg; bound to consistent_hash_ring_lookup below.
module chrl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import chrl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: the sequencer leaves idle after taking one
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // an empty-ring answer carries no owner and no points
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[14:0] == 15'd0)
        else $error("empty status with owner or points");

    // status is never the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL
            || m_axis_tuser == ST_EMPTY)
        else $error("bad status code");

endmodule

bind consistent_hash_ring_lookup chrl_checker u_chrl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
